### rtl/tamf_pkg.sv
// Shared constants and types for the three-axis trimmed mean filter.
package tamf_pkg;

  // Window length, axis count and field widths.
  localparam int WINDOW   = 10;
  localparam int AXES     = 3;
  localparam int SAMPLE_W = 16;
  localparam int OFFS_W   = 12;
  localparam int OUT_W    = 20;
  localparam int CFG_IDX_W = 2;

  // Offset register reset values.
  localparam logic signed [OFFS_W-1:0] OFFS_X_RST = 12'sd123;
  localparam logic signed [OFFS_W-1:0] OFFS_Y_RST = 12'sd30;
  localparam logic signed [OFFS_W-1:0] OFFS_Z_RST = 12'sd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_Z = 2'd2;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  // Control from the sequencer to the shared accumulate unit.
  typedef struct packed {
    logic en;
    logic first;
  } acc_ctrl_t;

endpackage

### rtl/tamf_hist.sv
// Sample history store: one shift line per axis, one read port.
module tamf_hist #(
  parameter int Window = tamf_pkg::WINDOW,
  localparam int Hist  = Window - 1,
  localparam int Depth = tamf_pkg::AXES * Hist,
  localparam int IdxW  = $clog2(Depth)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [IdxW-1:0]                     rd_idx_i,
  output logic signed [tamf_pkg::SAMPLE_W-1:0] rd_data_o,
  input  logic                                shift_en_i,
  input  logic [1:0]                          shift_axis_i,
  input  logic signed [tamf_pkg::SAMPLE_W-1:0] fresh_i
);

  logic signed [tamf_pkg::SAMPLE_W-1:0] hist_q [Depth];

  // Single read port.
  assign rd_data_o = hist_q[rd_idx_i];

  // Shift the chosen axis by one place; the fresh sample enters at the head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        hist_q[i] <= '0;
      end
    end else if (shift_en_i) begin
      for (int a = 0; a < tamf_pkg::AXES; a++) begin
        if (shift_axis_i == 2'(a)) begin
          hist_q[a*Hist] <= fresh_i;
          for (int k = 1; k < Hist; k++) begin
            hist_q[a*Hist + k] <= hist_q[a*Hist + k - 1];
          end
        end
      end
    end
  end

endmodule

### rtl/tamf_acc.sv
// Shared accumulate unit: running sum, maximum and minimum, then the trimmed result.
module tamf_acc #(
  parameter int Window = tamf_pkg::WINDOW,
  localparam int Kept  = Window - 2,
  localparam int AccW  = tamf_pkg::SAMPLE_W + $clog2(Window),
  localparam int ResW  = AccW + 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tamf_pkg::acc_ctrl_t                  ctrl_i,
  input  logic signed [tamf_pkg::SAMPLE_W-1:0] value_i,
  input  logic signed [tamf_pkg::OFFS_W-1:0]   offset_i,
  output logic signed [tamf_pkg::OUT_W-1:0]    result_o
);

  logic signed [AccW-1:0]              sum_q, sum_d;
  logic signed [tamf_pkg::SAMPLE_W-1:0] hi_q, hi_d, lo_q, lo_d;
  logic signed [ResW-1:0]              res_w;

  // One value per cycle while enabled: a fresh start or an add and two compares.
  always_comb begin
    sum_d = sum_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (ctrl_i.en) begin
      if (ctrl_i.first) begin
        sum_d = AccW'(value_i);
        hi_d  = value_i;
        lo_d  = value_i;
      end else begin
        sum_d = sum_q + AccW'(value_i);
        if (value_i > hi_q) begin
          hi_d = value_i;
        end
        if (value_i < lo_q) begin
          lo_d = value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      hi_q  <= '0;
      lo_q  <= '0;
    end else begin
      sum_q <= sum_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

  // Drop the extremes, add the rounding half and take off the scaled offset.
  assign res_w = ResW'(sum_q) - ResW'(hi_q) - ResW'(lo_q) + ResW'(Kept / 2)
               - ResW'(offset_i) * ResW'(Kept);
  assign result_o = res_w[tamf_pkg::OUT_W-1:0];

endmodule

### rtl/three_axis_trimmed_mean_filter_unit.sv
// Top level of the three-axis trimmed mean filter with its sequencer.
//
// Usage: an input transfer (in_valid_i high, in_stall_o low) carries one signed
// sample per axis. For each axis the block keeps the nine previous samples and
// forms sum-of-ten minus largest minus smallest, plus 4, minus eight times the
// axis offset, in eighths of an LSB. One result transfer follows each input.
// A single accumulate unit walks the window one value per cycle, axis by axis,
// with a finishing step per axis that stores its result and shifts its history.
// After the z axis the results are loaded into the output register and shown
// on out_valid_o, and only then is a new sample taken. in_stall_o is high
// while an item is being worked on. The result sits in an output register, so
// the next input is taken while a result waits; when the receiver stalls with
// a result already waiting, the finished item holds until the register frees.
// Offsets are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must
// write them only while idle; the block does not enforce it. Indexes beyond
// the z offset are ignored. Reset zeroes all history, offsets get 123, 30, 0.
module three_axis_trimmed_mean_filter_unit #(
  parameter int Window = tamf_pkg::WINDOW
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tamf_pkg::SAMPLE_W-1:0]  accel_x_i,
  input  logic signed [tamf_pkg::SAMPLE_W-1:0]  accel_y_i,
  input  logic signed [tamf_pkg::SAMPLE_W-1:0]  accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tamf_pkg::OUT_W-1:0]     filtered_x_o,
  output logic signed [tamf_pkg::OUT_W-1:0]     filtered_y_o,
  output logic signed [tamf_pkg::OUT_W-1:0]     filtered_z_o,
  input  logic                                  cfg_we_i,
  input  logic [tamf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tamf_pkg::OFFS_W-1:0]           cfg_wdata_i
);

  localparam int Hist  = Window - 1;
  localparam int Depth = tamf_pkg::AXES * Hist;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Window + 1);

  tamf_pkg::state_e state_q, state_d;

  logic [1:0]      axis_q, axis_d;
  logic [CntW-1:0] k_q, k_d;

  logic signed [tamf_pkg::SAMPLE_W-1:0] fresh_q [tamf_pkg::AXES];
  logic signed [tamf_pkg::OUT_W-1:0]    res_q   [tamf_pkg::AXES];
  logic signed [tamf_pkg::OFFS_W-1:0]   offs_q  [tamf_pkg::AXES];
  logic signed [tamf_pkg::OUT_W-1:0]    out_q   [tamf_pkg::AXES];
  logic                                 out_valid_q;

  logic in_xfer, out_xfer;
  logic step_last, axis_last;
  logic do_finish, do_load;

  tamf_pkg::acc_ctrl_t                  acc_ctrl;
  logic signed [tamf_pkg::SAMPLE_W-1:0] hist_rd, fresh_sel, acc_value;
  logic signed [tamf_pkg::OUT_W-1:0]    acc_result;
  logic [IdxW-1:0]                      rd_idx;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_q && !out_stall_i;
  assign step_last = (k_q == CntW'(Window));
  assign axis_last = (axis_q == tamf_pkg::AXIS_Z);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tamf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tamf_pkg::ST_RUN;
        end
      end
      tamf_pkg::ST_RUN: begin
        if (step_last && axis_last) begin
          state_d = tamf_pkg::ST_WAIT;
        end
      end
      tamf_pkg::ST_WAIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = tamf_pkg::ST_IDLE;
        end
      end
      default: state_d = tamf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o     = 1'b1;
    acc_ctrl.en    = 1'b0;
    acc_ctrl.first = 1'b0;
    do_finish      = 1'b0;
    do_load        = 1'b0;
    case (state_q)
      tamf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      tamf_pkg::ST_RUN: begin
        acc_ctrl.en    = !step_last;
        acc_ctrl.first = (k_q == '0);
        do_finish      = step_last;
      end
      tamf_pkg::ST_WAIT: begin
        do_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Axis and window position counters.
  always_comb begin
    axis_d = axis_q;
    k_d    = k_q;
    if (in_xfer) begin
      axis_d = tamf_pkg::AXIS_X;
      k_d    = '0;
    end else if (state_q == tamf_pkg::ST_RUN) begin
      if (step_last) begin
        axis_d = axis_q + 2'd1;
        k_d    = '0;
      end else begin
        k_d = k_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tamf_pkg::ST_IDLE;
      axis_q  <= tamf_pkg::AXIS_X;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      k_q     <= k_d;
    end
  end

  // Capture the samples of an accepted transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fresh_q[0] <= accel_x_i;
      fresh_q[1] <= accel_y_i;
      fresh_q[2] <= accel_z_i;
    end
  end

  // Offset registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q[0] <= tamf_pkg::OFFS_X_RST;
      offs_q[1] <= tamf_pkg::OFFS_Y_RST;
      offs_q[2] <= tamf_pkg::OFFS_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tamf_pkg::REG_OFFS_X: offs_q[0] <= cfg_wdata_i;
        tamf_pkg::REG_OFFS_Y: offs_q[1] <= cfg_wdata_i;
        tamf_pkg::REG_OFFS_Z: offs_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Value selection: the fresh sample first, then the history of the axis.
  assign fresh_sel = fresh_q[axis_q];
  assign rd_idx    = IdxW'(axis_q) * IdxW'(Hist) + IdxW'(k_q) - IdxW'(1);
  assign acc_value = (k_q == '0) ? fresh_sel : hist_rd;

  tamf_hist #(
    .Window (Window)
  ) u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_idx_i     (rd_idx),
    .rd_data_o    (hist_rd),
    .shift_en_i   (do_finish),
    .shift_axis_i (axis_q),
    .fresh_i      (fresh_sel)
  );

  tamf_acc #(
    .Window (Window)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .value_i  (acc_value),
    .offset_i (offs_q[axis_q]),
    .result_o (acc_result)
  );

  // Per-axis results, held until the output register is free.
  always_ff @(posedge clk_i) begin
    if (do_finish) begin
      res_q[axis_q] <= acc_result;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_x_o = out_q[0];
  assign filtered_y_o = out_q[1];
  assign filtered_z_o = out_q[2];

endmodule
